// ===== rtl/core/letterbox_viewport_fit_defines.svh =====
// ----------------------------------------------------------------------------
// Letterbox viewport fit assertion macros
// Concurrent checks that sample on the rising clock edge and stay quiet
// while reset is high. Defining NO_ASSERTIONS removes them.
// ----------------------------------------------------------------------------
`ifndef LETTERBOX_VIEWPORT_FIT_DEFINES_SVH
`define LETTERBOX_VIEWPORT_FIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define LVF_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("letterbox_viewport_fit: assertion failed");

// Next-cycle implication.
`define LVF_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("letterbox_viewport_fit: assertion failed");

`else

`define LVF_ASSERT_IMPL(lbl, ante, cons)
`define LVF_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/core/lvf_pkg.sv =====
// ----------------------------------------------------------------------------
// Letterbox viewport fit package
// Default sizes, result field widths and register map of the fit block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lvf_pkg;

   // Default frame dimension width and fraction width of the scale factors.
   localparam int DIM_BITS_DEFAULT  = 14;
   localparam int FRAC_BITS_DEFAULT = 16;

   // Fixed widths of the result fields.
   localparam int POS_W   = 14;
   localparam int SCALE_W = 30;

   // Register port geometry: 32-bit registers at byte address 4*index.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_INTEGER_SCALING = 1'b0
   } csr_index_type;

endpackage

// ===== rtl/core/letterbox_viewport_fit.sv =====
// ----------------------------------------------------------------------------
// Letterbox viewport fit
// Fits a source frame into a window at the source aspect ratio, centers it,
// and returns the destination rectangle and the Q14.16 scale factors.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Contents
//   req_*     in         req_valid / req_ready  source and window sizes
//   rsp_*     out        rsp_valid / rsp_ready  offsets, size, scale factors
//   APB       in/out     psel/penable, pready   integer_scaling at address 0
//
// A word passes input capture, cross products, the fit divider, the whole
// scale and offset stages, the scale dividers and the output register; one
// word is taken every cycle while the skid is empty. Two unrolled restoring
// dividers take one quotient bit per stage: DIM_BITS stages for the fit,
// then DIM_BITS + FRAC_BITS stages for the scale factors.
// Reset clears all valid bits and the integer_scaling register.
// If the output word is not taken, the next one parks in a skid register and
// req_ready drops the cycle after; nothing in flight is dropped or repeated.
`timescale 1ns / 1ps
`include "letterbox_viewport_fit_defines.svh"

module letterbox_viewport_fit #(
   parameter int DIM_BITS  = lvf_pkg::DIM_BITS_DEFAULT,
   parameter int FRAC_BITS = lvf_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [DIM_BITS-1:0]            req_source_width,
   input  logic [DIM_BITS-1:0]            req_source_height,
   input  logic [DIM_BITS-1:0]            req_window_width,
   input  logic [DIM_BITS-1:0]            req_window_height,

   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [lvf_pkg::POS_W-1:0]      rsp_dest_x,
   output logic [lvf_pkg::POS_W-1:0]      rsp_dest_y,
   output logic [lvf_pkg::POS_W-1:0]      rsp_fit_width,
   output logic [lvf_pkg::POS_W-1:0]      rsp_fit_height,
   output logic [lvf_pkg::SCALE_W-1:0]    rsp_scale_x,
   output logic [lvf_pkg::SCALE_W-1:0]    rsp_scale_y,

   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [lvf_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [lvf_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [lvf_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);

   import lvf_pkg::*;

   localparam int D  = DIM_BITS;
   localparam int QW = DIM_BITS + FRAC_BITS;
   localparam int SD = DIM_BITS + FRAC_BITS;

   localparam logic [QW-1:0] SCALE_ONE = QW'(1) << FRAC_BITS;

   typedef struct packed {
      logic [D-1:0] rem;
      logic [D-1:0] qn;
   } qlane_type;

   typedef struct packed {
      logic [D-1:0]  rem;
      logic [QW-1:0] qn;
   } slane_type;

   typedef struct packed {
      logic [D-1:0] sw;
      logic [D-1:0] sh;
      logic [D-1:0] ww;
      logic [D-1:0] wh;
      logic         intsc;
   } s0_type;

   typedef struct packed {
      logic [D-1:0]   sw;
      logic [D-1:0]   sh;
      logic [D-1:0]   ww;
      logic [D-1:0]   wh;
      logic           intsc;
      logic           zero;
      logic [2*D-1:0] pa;
      logic [2*D-1:0] pb;
   } s1_type;

   typedef struct packed {
      qlane_type    kx;
      qlane_type    ky;
      qlane_type    fit;
      logic [D-1:0] fit_den;
      logic [D-1:0] sw;
      logic [D-1:0] sh;
      logic [D-1:0] ww;
      logic [D-1:0] wh;
      logic         intsc;
      logic         zero;
      logic         wlim;
   } dv_type;

   typedef struct packed {
      logic [D-1:0] dw_int;
      logic [D-1:0] dh_int;
      logic         use_int;
      logic [D-1:0] fitq;
      logic [D-1:0] sw;
      logic [D-1:0] sh;
      logic [D-1:0] ww;
      logic [D-1:0] wh;
      logic         zero;
      logic         wlim;
   } s3_type;

   typedef struct packed {
      logic [D-1:0] dw;
      logic [D-1:0] dh;
      logic [D-1:0] x;
      logic [D-1:0] y;
      logic [D-1:0] sw;
      logic [D-1:0] sh;
      logic [D-1:0] ww;
      logic [D-1:0] wh;
      logic         zero;
   } s4_type;

   typedef struct packed {
      slane_type    sx;
      slane_type    sy;
      logic [D-1:0] sw;
      logic [D-1:0] sh;
      logic [D-1:0] dw;
      logic [D-1:0] dh;
      logic [D-1:0] x;
      logic [D-1:0] y;
      logic         zero;
   } sc_type;

   typedef struct packed {
      logic [POS_W-1:0]   x;
      logic [POS_W-1:0]   y;
      logic [POS_W-1:0]   dw;
      logic [POS_W-1:0]   dh;
      logic [SCALE_W-1:0] sx;
      logic [SCALE_W-1:0] sy;
   } res_type;

   // One restoring division step: bring in the next numerator bit, subtract
   // the divisor if it fits, and shift the quotient bit in at the bottom.
   function automatic qlane_type qstep(qlane_type l, logic [D-1:0] den);
      logic [D:0] t;
      logic       ge;
      qlane_type  r;
      t      = {l.rem, l.qn[D-1]};
      ge     = (t >= {1'b0, den});
      r.rem  = ge ? D'(t - {1'b0, den}) : t[D-1:0];
      r.qn   = {l.qn[D-2:0], ge};
      return r;
   endfunction

   function automatic slane_type sstep(slane_type l, logic [D-1:0] den);
      logic [D:0] t;
      logic       ge;
      slane_type  r;
      t      = {l.rem, l.qn[QW-1]};
      ge     = (t >= {1'b0, den});
      r.rem  = ge ? D'(t - {1'b0, den}) : t[D-1:0];
      r.qn   = {l.qn[QW-2:0], ge};
      return r;
   endfunction

   function automatic dv_type dv_advance(dv_type l);
      dv_type r;
      r     = l;
      r.kx  = qstep(l.kx, l.sw);
      r.ky  = qstep(l.ky, l.sh);
      r.fit = qstep(l.fit, l.fit_den);
      return r;
   endfunction

   function automatic sc_type sc_advance(sc_type l);
      sc_type r;
      r    = l;
      r.sx = sstep(l.sx, l.sw);
      r.sy = sstep(l.sy, l.sh);
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Register port
   // ------------------------------------------------------------------
   logic          integer_scaling_ff;
   csr_index_type csr_idx;
   logic          csr_write;

   assign pready    = 1'b1;
   assign csr_idx   = csr_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign csr_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         integer_scaling_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_idx)
            REG_INTEGER_SCALING: integer_scaling_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_INTEGER_SCALING: prdata = CSR_DATA_W'(integer_scaling_ff);
         default:             prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Pipeline control: every stage moves together unless the skid is full.
   // ------------------------------------------------------------------
   logic    pipe_en;
   logic    pipe_fire;
   logic    rsp_fire;
   logic    out_valid_ff;
   logic    skid_valid_ff;
   res_type out_ff;
   res_type skid_ff;
   res_type res_in;

   assign pipe_en   = ~skid_valid_ff;
   assign req_ready = pipe_en;
   assign rsp_valid = out_valid_ff;
   assign rsp_fire  = out_valid_ff & rsp_ready;

   // Stage 0: input capture.
   logic   s0_valid_ff;
   s0_type s0_ff;
   s0_type s0_in;

   assign s0_in = '{sw: req_source_width, sh: req_source_height,
                    ww: req_window_width, wh: req_window_height,
                    intsc: integer_scaling_ff};

   // Stage 1: cross products that pick the limiting axis.
   logic   s1_valid_ff;
   s1_type s1_ff;
   s1_type s1_in;

   always_comb begin
      s1_in.sw    = s0_ff.sw;
      s1_in.sh    = s0_ff.sh;
      s1_in.ww    = s0_ff.ww;
      s1_in.wh    = s0_ff.wh;
      s1_in.intsc = s0_ff.intsc;
      s1_in.zero  = (s0_ff.sw == '0) | (s0_ff.sh == '0) |
                    (s0_ff.ww == '0) | (s0_ff.wh == '0);
      s1_in.pa    = s0_ff.ww * s0_ff.sh;
      s1_in.pb    = s0_ff.wh * s0_ff.sw;
   end

   // Fit divider: whole-factor quotients and the fitted size in parallel.
   // The fitted size never exceeds the window, so the upper half of its
   // numerator is already below the divisor and only DIM_BITS steps remain.
   logic   dv_valid_ff [0:D];
   dv_type dv_ff       [0:D];
   dv_type dv_in;

   always_comb begin
      logic [2*D-1:0] num;
      dv_in.wlim    = (s1_ff.pa < s1_ff.pb);
      num           = dv_in.wlim ? s1_ff.pa : s1_ff.pb;
      dv_in.fit_den = dv_in.wlim ? s1_ff.sw : s1_ff.sh;
      dv_in.kx      = '{rem: '0, qn: s1_ff.ww};
      dv_in.ky      = '{rem: '0, qn: s1_ff.wh};
      dv_in.fit     = '{rem: num[2*D-1:D], qn: num[D-1:0]};
      dv_in.sw      = s1_ff.sw;
      dv_in.sh      = s1_ff.sh;
      dv_in.ww      = s1_ff.ww;
      dv_in.wh      = s1_ff.wh;
      dv_in.intsc   = s1_ff.intsc;
      dv_in.zero    = s1_ff.zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= D; j++) begin
            dv_valid_ff[j] <= 1'b0;
         end
      end else if (pipe_en) begin
         dv_valid_ff[0] <= s1_valid_ff;
         for (int j = 0; j < D; j++) begin
            dv_valid_ff[j+1] <= dv_valid_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         dv_ff[0] <= dv_in;
         for (int j = 0; j < D; j++) begin
            dv_ff[j+1] <= dv_advance(dv_ff[j]);
         end
      end
   end

   // Stage 3: whole scale factor and the integer-scaled size.
   logic   s3_valid_ff;
   s3_type s3_ff;
   s3_type s3_in;

   always_comb begin
      logic [D-1:0] k;
      k             = (dv_ff[D].kx.qn < dv_ff[D].ky.qn) ? dv_ff[D].kx.qn : dv_ff[D].ky.qn;
      s3_in.use_int = dv_ff[D].intsc & (k != '0);
      s3_in.dw_int  = D'(dv_ff[D].sw * k);
      s3_in.dh_int  = D'(dv_ff[D].sh * k);
      s3_in.fitq    = dv_ff[D].fit.qn;
      s3_in.sw      = dv_ff[D].sw;
      s3_in.sh      = dv_ff[D].sh;
      s3_in.ww      = dv_ff[D].ww;
      s3_in.wh      = dv_ff[D].wh;
      s3_in.zero    = dv_ff[D].zero;
      s3_in.wlim    = dv_ff[D].wlim;
   end

   // Stage 4: destination size and centering offsets.
   logic   s4_valid_ff;
   s4_type s4_ff;
   s4_type s4_in;

   always_comb begin
      if (s3_ff.zero) begin
         s4_in.dw = s3_ff.ww;
         s4_in.dh = s3_ff.wh;
      end else if (s3_ff.use_int) begin
         s4_in.dw = s3_ff.dw_int;
         s4_in.dh = s3_ff.dh_int;
      end else if (s3_ff.wlim) begin
         s4_in.dw = s3_ff.ww;
         s4_in.dh = s3_ff.fitq;
      end else begin
         s4_in.dw = s3_ff.fitq;
         s4_in.dh = s3_ff.wh;
      end
      s4_in.x    = D'((s3_ff.ww - s4_in.dw) >> 1);
      s4_in.y    = D'((s3_ff.wh - s4_in.dh) >> 1);
      s4_in.sw   = s3_ff.sw;
      s4_in.sh   = s3_ff.sh;
      s4_in.ww   = s3_ff.ww;
      s4_in.wh   = s3_ff.wh;
      s4_in.zero = s3_ff.zero;
   end

   // Scale dividers: dest << FRAC_BITS over source, one bit per stage.
   logic   sc_valid_ff [0:SD];
   sc_type sc_ff       [0:SD];
   sc_type sc_in;

   always_comb begin
      sc_in.sx   = '{rem: '0, qn: {s4_ff.dw, {FRAC_BITS{1'b0}}}};
      sc_in.sy   = '{rem: '0, qn: {s4_ff.dh, {FRAC_BITS{1'b0}}}};
      sc_in.sw   = s4_ff.sw;
      sc_in.sh   = s4_ff.sh;
      sc_in.dw   = s4_ff.dw;
      sc_in.dh   = s4_ff.dh;
      sc_in.x    = s4_ff.x;
      sc_in.y    = s4_ff.y;
      sc_in.zero = s4_ff.zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= SD; j++) begin
            sc_valid_ff[j] <= 1'b0;
         end
      end else if (pipe_en) begin
         sc_valid_ff[0] <= s4_valid_ff;
         for (int j = 0; j < SD; j++) begin
            sc_valid_ff[j+1] <= sc_valid_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         sc_ff[0] <= sc_in;
         for (int j = 0; j < SD; j++) begin
            sc_ff[j+1] <= sc_advance(sc_ff[j]);
         end
      end
   end

   // Stage registers in front of and between the dividers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s0_valid_ff <= req_valid;
         s1_valid_ff <= s0_valid_ff;
         s3_valid_ff <= dv_valid_ff[D];
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s0_ff <= s0_in;
         s1_ff <= s1_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
      end
   end

   // ------------------------------------------------------------------
   // Output register with skid
   // ------------------------------------------------------------------
   assign pipe_fire = pipe_en & sc_valid_ff[SD];

   always_comb begin
      res_in.x  = POS_W'(sc_ff[SD].x);
      res_in.y  = POS_W'(sc_ff[SD].y);
      res_in.dw = POS_W'(sc_ff[SD].dw);
      res_in.dh = POS_W'(sc_ff[SD].dh);
      res_in.sx = SCALE_W'(sc_ff[SD].zero ? SCALE_ONE : sc_ff[SD].sx.qn);
      res_in.sy = SCALE_W'(sc_ff[SD].zero ? SCALE_ONE : sc_ff[SD].sy.qn);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_fire) begin
         out_valid_ff  <= skid_valid_ff | pipe_fire;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff) begin
         out_valid_ff  <= pipe_fire;
      end else if (pipe_fire) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_fire) begin
         out_ff <= skid_valid_ff ? skid_ff : res_in;
      end else if (!out_valid_ff) begin
         out_ff <= res_in;
      end
      if (!rsp_fire && out_valid_ff && pipe_fire) begin
         skid_ff <= res_in;
      end
   end

   assign rsp_dest_x     = out_ff.x;
   assign rsp_dest_y     = out_ff.y;
   assign rsp_fit_width  = out_ff.dw;
   assign rsp_fit_height = out_ff.dh;
   assign rsp_scale_x    = out_ff.sx;
   assign rsp_scale_y    = out_ff.sy;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `LVF_ASSERT_IMPL(a_skid_behind_out, skid_valid_ff, out_valid_ff)
   `LVF_ASSERT_IMPL(a_skid_on_stall, $rose(skid_valid_ff), $past(out_valid_ff & ~rsp_ready))
   `LVF_ASSERT_IMPL(a_dest_in_window, s4_valid_ff, (s4_ff.dw <= s4_ff.ww) && (s4_ff.dh <= s4_ff.wh))

endmodule

// ===== test/tb_letterbox_viewport_fit.sv =====
// ----------------------------------------------------------------------------
// Letterbox viewport fit testbench
// Sends source and window sizes to the fit block and checks every returned
// rectangle and scale pair against a predictor held in this file. A short
// directed pass covers unknown sizes, size extremes, both limiting axes, the
// aspect tie and whole-number scaling. Random traffic follows, with idle
// gaps on both channels and register changes between bursts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_letterbox_viewport_fit;

   import lvf_pkg::*;

   localparam int          DIM_W       = DIM_BITS_DEFAULT;
   localparam int          FRAC_W      = FRAC_BITS_DEFAULT;
   localparam int          LATENCY     = 2 * DIM_W + FRAC_W + 7;
   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned REPORT_MAX  = 10;

   // Index 1 decodes to no register; writes there must be ignored.
   localparam logic [CSR_IDX_W-1:0] IDX_UNMAPPED = 1'b1;

   typedef logic [DIM_W-1:0]   dim_type;
   typedef logic [POS_W-1:0]   pos_type;
   typedef logic [SCALE_W-1:0] scale_type;

   typedef struct packed {
      dim_type source_width;
      dim_type source_height;
      dim_type window_width;
      dim_type window_height;
   } request_type;

   typedef struct packed {
      pos_type   dest_x;
      pos_type   dest_y;
      pos_type   fit_width;
      pos_type   fit_height;
      scale_type scale_x;
      scale_type scale_y;
   } fit_type;

   logic clock = 1'b0;
   logic reset;

   logic    req_valid;
   logic    req_ready;
   dim_type req_source_width;
   dim_type req_source_height;
   dim_type req_window_width;
   dim_type req_window_height;

   logic      rsp_valid;
   logic      rsp_ready = 1'b0;
   pos_type   rsp_dest_x;
   pos_type   rsp_dest_y;
   pos_type   rsp_fit_width;
   pos_type   rsp_fit_height;
   scale_type rsp_scale_x;
   scale_type rsp_scale_y;

   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   fit_type     pending_fits[$];
   bit          integer_scaling_q = 1'b0;
   bit          rsp_stalls_on = 1'b1;
   int unsigned rsp_stall_left = 0;
   int unsigned cycle_count = 0;
   int unsigned failures = 0;
   int unsigned requests_sent = 0;
   int unsigned scaled_requests = 0;
   int unsigned results_checked = 0;
   int unsigned csr_writes = 0;

   letterbox_viewport_fit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_source_width  (req_source_width),
      .req_source_height (req_source_height),
      .req_window_width  (req_window_width),
      .req_window_height (req_window_height),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_dest_x        (rsp_dest_x),
      .rsp_dest_y        (rsp_dest_y),
      .rsp_fit_width     (rsp_fit_width),
      .rsp_fit_height    (rsp_fit_height),
      .rsp_scale_x       (rsp_scale_x),
      .rsp_scale_y       (rsp_scale_y),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Largest aspect-preserving rectangle, centered, with floored Q scale factors.
   function automatic fit_type fit_window(input request_type r, input bit whole_steps);
      longint unsigned sw, sh, ww, wh, dw, dh, kx, ky, k, unity;
      fit_type         f;
      sw    = r.source_width;
      sh    = r.source_height;
      ww    = r.window_width;
      wh    = r.window_height;
      unity = longint'(1) << FRAC_W;
      if (sw == 0 || sh == 0 || ww == 0 || wh == 0) begin
         dw        = ww;
         dh        = wh;
         f.scale_x = scale_type'(unity);
         f.scale_y = scale_type'(unity);
      end else begin
         kx = ww / sw;
         ky = wh / sh;
         k  = (kx < ky) ? kx : ky;
         if (whole_steps && k >= 1) begin
            dw = sw * k;
            dh = sh * k;
         end else if (ww * sh < wh * sw) begin
            dw = ww;
            dh = (sh * ww) / sw;
         end else begin
            dh = wh;
            dw = (sw * wh) / sh;
         end
         f.scale_x = scale_type'((dw << FRAC_W) / sw);
         f.scale_y = scale_type'((dh << FRAC_W) / sh);
      end
      f.dest_x     = pos_type'((ww - dw) / 2);
      f.dest_y     = pos_type'((wh - dh) / 2);
      f.fit_width  = pos_type'(dw);
      f.fit_height = pos_type'(dh);
      return f;
   endfunction

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int unsigned idle_cycles();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 65) return 0;
      if (sel < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic dim_type random_dim();
      int unsigned sel;
      sel = $urandom_range(0, 39);
      if (sel == 0) return '0;
      if (sel == 1) return '1;
      if (sel < 12) return dim_type'($urandom_range(1, 64));
      if (sel < 20) return dim_type'($urandom_range(1, 2048));
      return dim_type'($urandom);
   endfunction

   function automatic request_type random_request();
      request_type r;
      int unsigned k;
      r.source_width  = random_dim();
      r.source_height = random_dim();
      r.window_width  = random_dim();
      r.window_height = random_dim();
      case ($urandom_range(0, 3))
         0: begin
            // Window is an exact multiple of the source, so the axes tie.
            k               = $urandom_range(1, 8);
            r.source_width  = dim_type'($urandom_range(1, 2047));
            r.source_height = dim_type'($urandom_range(1, 2047));
            r.window_width  = dim_type'(r.source_width * k);
            r.window_height = dim_type'(r.source_height * k);
         end
         1: begin
            // A whole multiple plus some slack on each axis.
            k               = $urandom_range(1, 8);
            r.source_width  = dim_type'($urandom_range(1, 1600));
            r.source_height = dim_type'($urandom_range(1, 1600));
            r.window_width  = dim_type'(r.source_width * k + $urandom_range(0, r.source_width));
            r.window_height = dim_type'(r.source_height * k +
                                        $urandom_range(0, r.source_height));
         end
         default: ;
      endcase
      return r;
   endfunction

   // Leaves valid high on return so that a following word goes out back to back.
   task automatic send_request(input request_type r);
      req_valid         <= 1'b1;
      req_source_width  <= r.source_width;
      req_source_height <= r.source_height;
      req_window_width  <= r.window_width;
      req_window_height <= r.window_height;
      do @(posedge clock); while (req_ready !== 1'b1);
      pending_fits.push_back(fit_window(r, integer_scaling_q));
      requests_sent++;
      if (integer_scaling_q) scaled_requests++;
   endtask

   task automatic send_fields(input int unsigned sw, input int unsigned sh,
                              input int unsigned ww, input int unsigned wh);
      send_request('{dim_type'(sw), dim_type'(sh), dim_type'(ww), dim_type'(wh)});
   endtask

   task automatic pause_sender(input int unsigned cycles);
      if (cycles != 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_fits.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_transfer(input logic [CSR_IDX_W-1:0] idx, input logic write_en,
                               input logic [CSR_DATA_W-1:0] wdata,
                               output logic [CSR_DATA_W-1:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write_en;
      paddr   <= {idx, 2'b00};
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      rdata = prdata;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (write_en) begin
         csr_writes++;
         if (idx == REG_INTEGER_SCALING) integer_scaling_q = wdata[0];
      end
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      logic [CSR_DATA_W-1:0] unused;
      csr_transfer(idx, 1'b1, data, unused);
   endtask

   task automatic check_readback();
      logic [CSR_DATA_W-1:0] value;
      csr_transfer(REG_INTEGER_SCALING, 1'b0, '0, value);
      if (value !== CSR_DATA_W'(integer_scaling_q)) begin
         failures++;
         if (failures <= REPORT_MAX)
            $display("integer_scaling readback: expected %0d, got %h", integer_scaling_q, value);
      end
   endtask

   task automatic test_unknown_sizes();
      send_fields(0, 1080, 1920, 1080);
      send_fields(1920, 0, 1920, 1080);
      send_fields(1920, 1080, 0, 1080);
      send_fields(1920, 1080, 1920, 0);
      send_fields(0, 0, 0, 0);
      send_fields(16383, 16383, 16383, 0);
   endtask

   task automatic test_fit_axes();
      send_fields(1920, 1080, 3840, 2160);
      send_fields(640, 480, 1920, 1080);
      send_fields(1920, 1080, 1000, 1000);
      send_fields(16383, 16383, 16383, 16383);
      send_fields(1, 1, 16383, 16383);
      send_fields(16383, 1, 1, 16383);
      send_fields(1, 16383, 16383, 1);
      send_fields(3, 7, 16382, 16381);
   endtask

   task automatic test_integer_scaling();
      drain_results();
      csr_write(REG_INTEGER_SCALING, 32'h0000_0001);
      check_readback();
      send_fields(640, 480, 1920, 1080);
      send_fields(1, 1, 16383, 16383);
      send_fields(16383, 16383, 16383, 16383);
      send_fields(1920, 1080, 1000, 1000);
      send_fields(100, 100, 299, 250);
      send_fields(0, 5, 10, 10);
   endtask

   task automatic test_unmapped_register();
      drain_results();
      csr_write(IDX_UNMAPPED, 32'h0000_0000);
      check_readback();
      send_fields(640, 480, 1920, 1080);
      drain_results();
      // Upper bits set, bit zero clear: only bit zero may take effect.
      csr_write(REG_INTEGER_SCALING, 32'hFFFF_FFFE);
      check_readback();
      send_fields(640, 480, 1920, 1080);
   endtask

   task automatic test_random_traffic(input int unsigned total);
      int unsigned           sent;
      int unsigned           burst;
      int unsigned           burst_len;
      bit                    calm;
      logic [CSR_DATA_W-1:0] data;
      sent  = 0;
      burst = 0;
      while (sent < total) begin
         burst_len     = $urandom_range(40, 160);
         calm          = ($urandom_range(0, 3) == 0);
         rsp_stalls_on = !calm;
         repeat (burst_len) begin
            send_request(random_request());
            if (!calm) pause_sender(idle_cycles());
         end
         sent += burst_len;
         // Let everything come back, then flip the scaling mode.
         if (burst == 0 || $urandom_range(0, 1) == 1) begin
            drain_results();
            if ($urandom_range(0, 3) == 0) csr_write(IDX_UNMAPPED, $urandom);
            data    = $urandom;
            data[0] = !integer_scaling_q;
            csr_write(REG_INTEGER_SCALING, data);
            if ($urandom_range(0, 2) == 0) check_readback();
         end
         burst++;
      end
      rsp_stalls_on = 1'b1;
   endtask

   task automatic finish_run();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_fits.size() != 0) @(posedge clock);
      repeat (2 * LATENCY) @(posedge clock);
      $display("Ran %0d requests (%0d with integer scaling), checked %0d results,",
               requests_sent, scaled_requests, results_checked);
      $display("made %0d register writes and saw %0d failures.", csr_writes, failures);
      if (failures == 0 && pending_fits.size() == 0) begin
         $display("letterbox_viewport_fit: match");
      end else begin
         $display("letterbox_viewport_fit: mismatch");
      end
      $finish;
   endtask

   always @(posedge clock) begin
      if (rsp_stall_left != 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_ready      <= 1'b0;
      end else if (rsp_stalls_on && $urandom_range(0, 4) == 0) begin
         rsp_stall_left <= idle_cycles();
         rsp_ready      <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      fit_type want;
      fit_type got;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         got = '{rsp_dest_x, rsp_dest_y, rsp_fit_width, rsp_fit_height,
                 rsp_scale_x, rsp_scale_y};
         results_checked++;
         if (pending_fits.size() == 0) begin
            failures++;
            if (failures <= REPORT_MAX)
               $display("unexpected word: x=%0d y=%0d w=%0d h=%0d sx=%h sy=%h",
                        got.dest_x, got.dest_y, got.fit_width, got.fit_height,
                        got.scale_x, got.scale_y);
         end else begin
            want = pending_fits.pop_front();
            if (got !== want) begin
               failures++;
               if (failures <= REPORT_MAX) begin
                  $display("word %0d expected: x=%0d y=%0d w=%0d h=%0d sx=%h sy=%h",
                           results_checked, want.dest_x, want.dest_y, want.fit_width,
                           want.fit_height, want.scale_x, want.scale_y);
                  $display("word %0d actual:   x=%0d y=%0d w=%0d h=%0d sx=%h sy=%h",
                           results_checked, got.dest_x, got.dest_y, got.fit_width,
                           got.fit_height, got.scale_x, got.scale_y);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d words outstanding.",
                  cycle_count, pending_fits.size());
         $display("letterbox_viewport_fit: mismatch");
         $finish;
      end
   end

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_source_width  = '0;
      req_source_height = '0;
      req_window_width  = '0;
      req_window_height = '0;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_unknown_sizes();
      test_fit_axes();
      test_integer_scaling();
      test_unmapped_register();
      test_random_traffic(1500);
      finish_run();
   end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/lvf_pkg.sv
rtl/core/letterbox_viewport_fit.sv
test/tb_letterbox_viewport_fit.sv
